FILE: rtl/core/idxh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package idxh_pkg;
    localparam int CAPACITY     = 64;
    localparam int ID_BITS      = 8;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int ID_COUNT     = 1 << ID_BITS;
    localparam int ADDR_BITS    = $clog2(CAPACITY);
    localparam int POS_BITS     = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_SET_KEY = 2'd1;
    localparam logic [1:0] OP_DEL_MIN = 2'd2;
    localparam logic [1:0] OP_REMOVE  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam logic signed [KEY_BITS-1:0] KEY_MOST_NEG = {1'b1, {(KEY_BITS-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                 opcode;
        logic [7:0]                 entry_id;
        logic signed [31:0]         new_key;
        logic [31:0]                payload;
    } t_in;

    typedef struct packed {
        logic [2:0]                 status;
        logic [7:0]                 out_id;
        logic signed [31:0]         out_key;
        logic [31:0]                out_payload;
    } t_out;

    typedef struct packed {
        logic [ID_BITS-1:0]         id;
        logic signed [KEY_BITS-1:0] key;
        logic [PAYLOAD_BITS-1:0]    pay;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_SK_RD, S_RM_RD, S_RM_ROOT, S_DM_RD, S_TAKE, S_TK_RD,
        S_SU_CHK, S_SU_CMP, S_PLACE, S_SD_CHK, S_SD_L, S_SD_R, S_SD_CMP, S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/core/idxh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module idxh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/indexed_min_heap.sv
`timescale 1ns / 1ps
`default_nettype none
// Indexed binary min-heap: insert, set key, delete minimum, remove by id.
// A rejected beat goes from S_DISP straight to S_DONE. Sifts share the one heap RAM read port:
// a level up takes S_SU_CHK, S_SU_CMP; a level down S_SD_CHK, S_SD_L, S_SD_R (skipped), S_SD_CMP.
// Throughput: one beat at a time; busy drops the cycle after the result strobe.
// The result is shown for one cycle on o_done; the receiver cannot stall it.
// Reset (sync, active low) empties the heap at once: id valid bits are flops.
module indexed_min_heap (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire idxh_pkg::t_in i_item,
    output logic               o_done,
    output idxh_pkg::t_out     o_result
);
    import idxh_pkg::*;

    // heap slots 1..CAPACITY live at RAM address slot-1
    logic                 heap_we;
    logic [ADDR_BITS-1:0] heap_waddr, heap_raddr;
    t_slot                heap_wdata, heap_rdata;
    // position table, 0 when the id's valid bit is clear
    logic                 pos_we;
    logic [ID_BITS-1:0]   pos_waddr, pos_raddr;
    logic [POS_BITS-1:0]  pos_wdata, pos_rdata;

    idxh_ram #(.WIDTH($bits(t_slot)), .DEPTH(CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_waddr(heap_waddr), .i_wdata(heap_wdata),
        .i_raddr(heap_raddr), .o_rdata(heap_rdata)
    );
    idxh_ram #(.WIDTH(POS_BITS), .DEPTH(ID_COUNT)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_rdata)
    );

    t_state              r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic [PAYLOAD_BITS-1:0]    r_pay, n_pay;
    logic [POS_BITS-1:0] r_cnt, n_cnt;
    logic [POS_BITS-1:0] r_h, n_h;         // current hole
    logic [POS_BITS-1:0] r_cpos, n_cpos;   // chosen child slot
    t_slot               r_e, n_e;         // entry being sifted
    t_slot               r_child, n_child;
    logic                r_take, n_take;   // remove: take root after sift up
    t_out                r_res, n_res;
    logic [ID_COUNT-1:0] r_valid;
    logic                vset, vclr;
    logic [ID_BITS-1:0]  vclr_id;
    logic [POS_BITS-1:0] pos_v;
    logic [POS_BITS:0]   left;             // 2h, one bit wider

    assign busy     = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;
    assign left     = {r_h, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_take  <= 1'b0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_take  <= n_take;
            if (vset) begin
                r_valid[pos_waddr] <= 1'b1;
            end
            if (vclr) begin
                r_valid[vclr_id] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_id    <= n_id;
        r_key   <= n_key;
        r_pay   <= n_pay;
        r_h     <= n_h;
        r_cpos  <= n_cpos;
        r_e     <= n_e;
        r_child <= n_child;
        r_res   <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_id    = r_id;
        n_key   = r_key;
        n_pay   = r_pay;
        n_cnt   = r_cnt;
        n_h     = r_h;
        n_cpos  = r_cpos;
        n_e     = r_e;
        n_child = r_child;
        n_take  = r_take;
        n_res   = r_res;
        heap_we    = 1'b0;
        heap_waddr = ADDR_BITS'(r_h - 1'b1);
        heap_wdata = r_e;
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = r_e.id;
        pos_wdata  = r_h;
        pos_raddr  = i_item.entry_id;
        vset    = 1'b0;
        vclr    = 1'b0;
        vclr_id = r_e.id;
        pos_v   = r_valid[r_id] ? pos_rdata : '0;
        if (pos_v > r_cnt) begin
            pos_v = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_item.opcode;
                    n_id  = i_item.entry_id;
                    n_key = (i_item.new_key == KEY_MOST_NEG) ?
                            i_item.new_key + 1'b1 : i_item.new_key;
                    n_pay = i_item.payload;
                    n_take = 1'b0;
                    n_res = '0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                heap_raddr = ADDR_BITS'(pos_v - 1'b1);
                n_h = pos_v;
                case (r_op)
                    OP_INSERT: begin
                        if (r_cnt == POS_BITS'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                            n_state = S_DONE;
                        end else if (pos_v != '0) begin
                            n_res.status = ST_DUP;
                            n_state = S_DONE;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                            n_h   = r_cnt + 1'b1;
                            n_e   = '{id: r_id, key: r_key, pay: r_pay};
                            n_state = S_SU_CHK;
                        end
                    end
                    OP_DEL_MIN: begin
                        heap_raddr = '0;
                        if (r_cnt == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_DM_RD;
                        end
                    end
                    default: begin
                        if (pos_v == '0) begin
                            n_res.status = ST_NOT_FOUND;
                            n_state = S_DONE;
                        end else begin
                            n_state = (r_op == OP_SET_KEY) ? S_SK_RD : S_RM_RD;
                        end
                    end
                endcase
            end
            S_SK_RD: begin
                n_e = '{id: heap_rdata.id, key: r_key, pay: heap_rdata.pay};
                if (heap_rdata.key < r_key) begin
                    n_state = S_SD_CHK;
                end else if (r_key < heap_rdata.key) begin
                    n_state = S_SU_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RM_RD: begin
                n_res.out_key     = heap_rdata.key;
                n_res.out_payload = heap_rdata.pay;
                n_e = heap_rdata;
                heap_raddr = '0;
                n_state = S_RM_ROOT;
            end
            S_RM_ROOT: begin
                n_e.key = heap_rdata.key - 1'b1;
                n_take  = 1'b1;
                n_state = S_SU_CHK;
            end
            S_DM_RD: begin
                n_res.out_id      = heap_rdata.id;
                n_res.out_key     = heap_rdata.key;
                n_res.out_payload = heap_rdata.pay;
                n_e = heap_rdata;
                n_state = S_TAKE;
            end
            S_TAKE: begin
                // root id leaves; last slot refills the root
                vclr = 1'b1;
                n_cnt = r_cnt - 1'b1;
                heap_raddr = ADDR_BITS'(r_cnt - 1'b1);
                n_h = POS_BITS'(1);
                n_state = (r_cnt == POS_BITS'(1)) ? S_DONE : S_TK_RD;
            end
            S_TK_RD: begin
                n_e = heap_rdata;
                n_state = S_SD_CHK;
            end
            S_SU_CHK: begin
                heap_raddr = ADDR_BITS'((r_h >> 1) - 1'b1);
                n_state = (r_h == POS_BITS'(1)) ? S_PLACE : S_SU_CMP;
            end
            S_SU_CMP: begin
                if (r_e.key < heap_rdata.key) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = heap_rdata.id;
                    n_h = r_h >> 1;
                    n_state = S_SU_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                vset    = 1'b1;
                n_take  = 1'b0;
                n_state = r_take ? S_TAKE : S_DONE;
            end
            S_SD_CHK: begin
                heap_raddr = ADDR_BITS'(left - 1'b1);
                n_cpos = POS_BITS'(left);
                n_state = (left > {1'b0, r_cnt}) ? S_PLACE : S_SD_L;
            end
            S_SD_L: begin
                n_child = heap_rdata;
                heap_raddr = ADDR_BITS'(r_cpos);
                n_state = (r_cpos == r_cnt) ? S_SD_CMP : S_SD_R;
            end
            S_SD_R: begin
                if (heap_rdata.key < r_child.key) begin
                    n_child = heap_rdata;
                    n_cpos  = r_cpos + 1'b1;
                end
                n_state = S_SD_CMP;
            end
            S_SD_CMP: begin
                if (r_child.key < r_e.key) begin
                    heap_we    = 1'b1;
                    heap_wdata = r_child;
                    pos_we     = 1'b1;
                    pos_waddr  = r_child.id;
                    n_h = r_cpos;
                    n_state = S_SD_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire
